// ===== sv/psd_pkg.sv =====
package psd_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // Derived widths of the datapath.
    localparam int DIFF_W  = COORD_BITS + 1;          // coordinate difference
    localparam int SQ_W    = 2 * DIFF_W;              // one product
    localparam int LEN_W   = SQ_W + 1;                // sum of two squares
    localparam int MAG_W   = SQ_W + 1;                // cross product and its magnitude
    localparam int DIST_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int QUO_W   = 2 * DIST_W;
    localparam int NUM_W   = QUO_W + LEN_W;

    localparam logic [1:0] PART_END   = 2'd0;
    localparam logic [1:0] PART_START = 2'd1;
    localparam logic [1:0] PART_MID   = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
    } query_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [1:0]        nearest_part;
    } result_t;

    typedef struct packed {
        logic       vld;
        logic [1:0] part;
    } tag_t;

endpackage

// ===== sv/psd_div.sv =====
module psd_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  psd_pkg::tag_t                  tag_in,
    input  logic [psd_pkg::NUM_W-1:0]      num,
    input  logic [psd_pkg::LEN_W-1:0]      den,
    output psd_pkg::tag_t                  tag_out,
    output logic [psd_pkg::QUO_W-1:0]      quo
);
    localparam int QW = psd_pkg::QUO_W;
    localparam int LW = psd_pkg::LEN_W;

    // One quotient bit per stage. The low numerator bits shift out of the
    // top of lq while quotient bits shift in at the bottom.
    logic [LW-1:0]   rem_in  [QW];
    logic [QW-1:0]   lq_in   [QW];
    logic [LW-1:0]   den_in  [QW];
    psd_pkg::tag_t   tag_in_s[QW];
    logic [LW-1:0]   rem_reg [QW];
    logic [QW-1:0]   lq_reg  [QW];
    logic [LW-1:0]   den_reg [QW];
    psd_pkg::tag_t   tag_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [LW:0]   r2;
        logic          ge;
        logic [LW:0]   diff;
        logic [LW-1:0] rem_next;
        logic [QW-1:0] lq_next;

        if (s == 0) begin : g_first
            assign rem_in[s]   = num[QW+LW-1:QW];
            assign lq_in[s]    = num[QW-1:0];
            assign den_in[s]   = den;
            assign tag_in_s[s] = tag_in;
        end else begin : g_next
            assign rem_in[s]   = rem_reg[s-1];
            assign lq_in[s]    = lq_reg[s-1];
            assign den_in[s]   = den_reg[s-1];
            assign tag_in_s[s] = tag_reg[s-1];
        end

        always_comb
        begin
            r2       = {rem_in[s], lq_in[s][QW-1]};
            diff     = r2 - {1'b0, den_in[s]};
            ge       = (r2 >= {1'b0, den_in[s]});
            rem_next = ge ? diff[LW-1:0] : r2[LW-1:0];
            lq_next  = {lq_in[s][QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else if (adv)
            begin
                tag_reg[s] <= tag_in_s[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= rem_next;
                lq_reg[s]  <= lq_next;
                den_reg[s] <= den_in[s];
            end
        end
    end

    assign tag_out = tag_reg[QW-1];
    assign quo     = lq_reg[QW-1];

endmodule

// ===== sv/psd_sqrt.sv =====
module psd_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  psd_pkg::tag_t                  tag_in,
    input  logic [psd_pkg::QUO_W-1:0]      rad,
    output psd_pkg::tag_t                  tag_out,
    output logic [psd_pkg::DIST_W-1:0]     root
);
    localparam int DW = psd_pkg::DIST_W;
    localparam int QW = psd_pkg::QUO_W;
    localparam int RW = DW + 2;

    // One root bit per stage, two radicand bits consumed per stage.
    logic [RW-1:0]   rem_in  [DW];
    logic [QW-1:0]   rad_in  [DW];
    logic [DW-1:0]   root_in [DW];
    psd_pkg::tag_t   tag_in_s[DW];
    logic [RW-1:0]   rem_reg [DW];
    logic [QW-1:0]   rad_reg [DW];
    logic [DW-1:0]   root_reg[DW];
    psd_pkg::tag_t   tag_reg [DW];

    for (genvar s = 0; s < DW; s++) begin : g_stage
        logic [RW+1:0] r4;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          ge;
        logic [RW-1:0] rem_next;

        if (s == 0) begin : g_first
            assign rem_in[s]   = '0;
            assign rad_in[s]   = rad;
            assign root_in[s]  = '0;
            assign tag_in_s[s] = tag_in;
        end else begin : g_next
            assign rem_in[s]   = rem_reg[s-1];
            assign rad_in[s]   = rad_reg[s-1];
            assign root_in[s]  = root_reg[s-1];
            assign tag_in_s[s] = tag_reg[s-1];
        end

        always_comb
        begin
            r4       = {rem_in[s], rad_in[s][QW-1:QW-2]};
            trial    = {2'b00, root_in[s], 2'b01};
            diff     = r4 - trial;
            ge       = (r4 >= trial);
            rem_next = ge ? diff[RW-1:0] : r4[RW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else if (adv)
            begin
                tag_reg[s] <= tag_in_s[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                rad_reg[s]  <= rad_in[s] << 2;
                root_reg[s] <= {root_in[s][DW-2:0], ge};
            end
        end
    end

    assign tag_out = tag_reg[DW-1];
    assign root    = root_reg[DW-1];

endmodule

// ===== sv/point_segment_distance.sv =====
// Channel   Signals                               Moves
// query     query_valid, query_ready, query       one segment and one point per transfer
// result    result_valid, result_ready, result    one distance and nearest-part code
//
// The block takes one query every cycle while no result waits untaken, and returns its
// result through 5 front stages, 50 divider stages and 25 square root stages.
// The latency is set by the long division, one quotient bit per stage, and the
// square root, one root bit per stage.
// Reset clears every valid bit; data registers are not reset.
// When a result waits untaken, the whole pipeline holds and query_ready is low.
module point_segment_distance (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_ready,
    input  psd_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_ready,
    output psd_pkg::result_t result
);
    localparam int DW  = psd_pkg::DIFF_W;
    localparam int SW  = psd_pkg::SQ_W;
    localparam int LW  = psd_pkg::LEN_W;
    localparam int MW  = psd_pkg::MAG_W;
    localparam int NW  = psd_pkg::NUM_W;
    localparam int QW  = psd_pkg::QUO_W;
    localparam int FB  = psd_pkg::FRAC_BITS;

    // The pipeline moves as a whole whenever the output register is free
    // or being emptied in this cycle.
    logic adv;
    assign adv         = !result_valid || result_ready;
    assign query_ready = adv;

    // Stage 1: coordinate differences.
    logic                 v1_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, lx_reg, ly_reg;

    // Stage 2: squares and the two cross-product terms.
    logic                 v2_reg;
    logic signed [SW-1:0] sax_reg, say_reg, sbx_reg, sby_reg, slx_reg, sly_reg;
    logic signed [SW-1:0] pla_reg, plb_reg;
    logic signed [SW-1:0] sax_next, say_next, sbx_next, sby_next, slx_next, sly_next;
    logic signed [SW-1:0] pla_next, plb_next;

    // Stage 3: squared distances, squared length and the cross product.
    logic                 v3_reg;
    logic [LW-1:0]        d1_reg, d2_reg, len_reg;
    logic signed [MW-1:0] cr_reg;

    // Stage 4: case decision and selection of the divider operands.
    psd_pkg::tag_t        t4_reg, t4_next;
    logic [LW-1:0]        dsel_reg, den4_reg, dsel_next, den4_next;
    logic [MW-1:0]        mag_reg, mag_next;
    logic [LW:0]          sum12, sum21;

    // Stage 5: numerator, scaled by the fraction bits squared.
    psd_pkg::tag_t        t5_reg;
    logic [NW-1:0]        num_reg, num_next;
    logic [LW-1:0]        den5_reg;
    logic [2*MW-1:0]      mag_sq;

    psd_pkg::tag_t        div_tag, sq_tag;
    logic [QW-1:0]        quo;
    logic [psd_pkg::DIST_W-1:0] root;

    always_comb
    begin
        sax_next = ax_reg * ax_reg;
        say_next = ay_reg * ay_reg;
        sbx_next = bx_reg * bx_reg;
        sby_next = by_reg * by_reg;
        slx_next = lx_reg * lx_reg;
        sly_next = ly_reg * ly_reg;
        pla_next = lx_reg * ay_reg;
        plb_next = ly_reg * ax_reg;
    end

    // A zero-length segment makes both distances equal, so it always takes
    // the end-point case and the divisor of the middle case is never zero.
    always_comb
    begin
        sum12 = {1'b0, d2_reg} + {1'b0, len_reg};
        sum21 = {1'b0, d1_reg} + {1'b0, len_reg};
        mag_next = cr_reg[MW-1] ? MW'(-cr_reg) : MW'(cr_reg);
        t4_next.vld = v3_reg;
        if ({1'b0, d1_reg} >= sum12)
        begin
            t4_next.part = psd_pkg::PART_END;
            dsel_next    = d2_reg;
            den4_next    = LW'(1);
        end
        else if ({1'b0, d2_reg} >= sum21)
        begin
            t4_next.part = psd_pkg::PART_START;
            dsel_next    = d1_reg;
            den4_next    = LW'(1);
        end
        else
        begin
            t4_next.part = psd_pkg::PART_MID;
            dsel_next    = d1_reg;
            den4_next    = len_reg;
        end
    end

    always_comb
    begin
        mag_sq = mag_reg * mag_reg;
        if (t4_reg.part == psd_pkg::PART_MID)
        begin
            num_next = NW'(mag_sq) << (2 * FB);
        end
        else
        begin
            num_next = NW'(dsel_reg) << (2 * FB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= query_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            t4_reg <= t4_next;
            t5_reg <= t4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg   <= DW'(query.query_x) - DW'(query.start_x);
            ay_reg   <= DW'(query.query_y) - DW'(query.start_y);
            bx_reg   <= DW'(query.query_x) - DW'(query.end_x);
            by_reg   <= DW'(query.query_y) - DW'(query.end_y);
            lx_reg   <= DW'(query.end_x) - DW'(query.start_x);
            ly_reg   <= DW'(query.end_y) - DW'(query.start_y);
            sax_reg  <= sax_next;
            say_reg  <= say_next;
            sbx_reg  <= sbx_next;
            sby_reg  <= sby_next;
            slx_reg  <= slx_next;
            sly_reg  <= sly_next;
            pla_reg  <= pla_next;
            plb_reg  <= plb_next;
            d1_reg   <= LW'($unsigned(sax_reg)) + LW'($unsigned(say_reg));
            d2_reg   <= LW'($unsigned(sbx_reg)) + LW'($unsigned(sby_reg));
            len_reg  <= LW'($unsigned(slx_reg)) + LW'($unsigned(sly_reg));
            cr_reg   <= MW'(pla_reg) - MW'(plb_reg);
            dsel_reg <= dsel_next;
            den4_reg <= den4_next;
            mag_reg  <= mag_next;
            num_reg  <= num_next;
            den5_reg <= den4_reg;
        end
    end

    psd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (t5_reg),
        .num     (num_reg),
        .den     (den5_reg),
        .tag_out (div_tag),
        .quo     (quo)
    );

    psd_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (div_tag),
        .rad     (quo),
        .tag_out (sq_tag),
        .root    (root)
    );

    assign result_valid        = sq_tag.vld;
    assign result.distance     = root;
    assign result.nearest_part = sq_tag.part;

    // The middle case always divides by a nonzero squared length.
    a_mid_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        t5_reg.vld && t5_reg.part == psd_pkg::PART_MID |-> den5_reg != '0)
        else $error("middle case entered with zero segment length");

    // The quotient must fit the divider: the numerator's high part is below
    // the divisor.
    a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
        t5_reg.vld |-> (num_reg >> QW) < NW'(den5_reg))
        else $error("divider quotient overflow");

    // End-point cases divide by one.
    a_end_den_one: assert property (@(posedge clk) disable iff (!rst_n)
        t5_reg.vld && t5_reg.part != psd_pkg::PART_MID |-> den5_reg == LW'(1))
        else $error("end-point case with divisor other than one");

    a_part_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.nearest_part == psd_pkg::PART_END
            || result.nearest_part == psd_pkg::PART_START
            || result.nearest_part == psd_pkg::PART_MID)
        else $error("bad nearest-part code");

endmodule

// ===== tb/sv/point_segment_distance_tb.sv =====
module point_segment_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is a deep pipeline (80 stages); the settle time at the end
    // and the receiver hold-off both cover that depth with room to spare.
    localparam int PIPE_DEPTH   = 80;
    localparam int RANDOM_ITEMS = 1250;
    localparam longint CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              query_valid;
    logic              query_ready;
    psd_pkg::query_t   query;
    logic              result_valid;
    logic              result_ready;
    psd_pkg::result_t  result;

    point_segment_distance i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Expected distances, oldest first.
    psd_pkg::result_t pending_results[$];
    int      mismatch_count;
    longint  cycle_count;
    bit      stimulus_done;

    // Idle chances in percent for each side, changed by phase.
    int sender_idle_pct;
    int receiver_idle_pct;
    // When set, the receiver refuses results for a long stretch.
    bit hold_results;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Largest k below 2^(DIST_W+1) with k*k*den <= num * 4^FRAC_BITS.
    // The widths here are wide enough that no product can overflow.
    function automatic logic [psd_pkg::DIST_W:0] floor_root_ratio(
        logic [2*psd_pkg::MAG_W-1:0] num,
        logic [psd_pkg::LEN_W-1:0]   den);
        logic [psd_pkg::DIST_W:0]  k;
        logic [psd_pkg::DIST_W:0]  trial;
        logic [255:0]              lim;
        logic [255:0]              prod;
        k = '0;
        lim = 256'(num) << (2 * psd_pkg::FRAC_BITS);
        for (int b = psd_pkg::DIST_W; b >= 0; b--)
        begin
            trial = k | ((psd_pkg::DIST_W + 1)'(1) << b);
            prod = 256'(trial) * 256'(trial) * 256'(den);
            if (prod <= lim)
            begin
                k = trial;
            end
        end
        return k;
    endfunction

    // Distance from the query point to the closed segment, in three cases.
    function automatic psd_pkg::result_t segment_distance(psd_pkg::query_t q);
        psd_pkg::result_t r;
        longint ax, ay, bx, by, lx, ly, cross_prod;
        longint d_start, d_end, seg_len;
        ax = longint'(q.query_x) - longint'(q.start_x);
        ay = longint'(q.query_y) - longint'(q.start_y);
        bx = longint'(q.query_x) - longint'(q.end_x);
        by = longint'(q.query_y) - longint'(q.end_y);
        lx = longint'(q.end_x) - longint'(q.start_x);
        ly = longint'(q.end_y) - longint'(q.start_y);
        d_start = ax * ax + ay * ay;
        d_end   = bx * bx + by * by;
        seg_len = lx * lx + ly * ly;
        if (d_start >= d_end + seg_len)
        begin
            r.distance = psd_pkg::DIST_W'(floor_root_ratio(
                (2*psd_pkg::MAG_W)'(d_end), psd_pkg::LEN_W'(1)));
            r.nearest_part = psd_pkg::PART_END;
        end
        else if (d_end >= d_start + seg_len)
        begin
            r.distance = psd_pkg::DIST_W'(floor_root_ratio(
                (2*psd_pkg::MAG_W)'(d_start), psd_pkg::LEN_W'(1)));
            r.nearest_part = psd_pkg::PART_START;
        end
        else
        begin
            cross_prod = lx * ay - ly * ax;
            if (cross_prod < 0)
            begin
                cross_prod = -cross_prod;
            end
            r.distance = psd_pkg::DIST_W'(floor_root_ratio(
                (2*psd_pkg::MAG_W)'(cross_prod) * (2*psd_pkg::MAG_W)'(cross_prod),
                psd_pkg::LEN_W'(seg_len)));
            r.nearest_part = psd_pkg::PART_MID;
        end
        return r;
    endfunction

    // Directed table: each row has a query and, where obvious, a typed-in
    // expectation. Rows without one are checked against the predictor.
    typedef struct {
        psd_pkg::query_t  q;
        bit               has_fixed;
        psd_pkg::result_t fixed;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic psd_pkg::query_t make_query(int sx, int sy, int ex, int ey,
                                                   int qx, int qy);
        psd_pkg::query_t q;
        q.start_x = psd_pkg::COORD_BITS'(sx);
        q.start_y = psd_pkg::COORD_BITS'(sy);
        q.end_x   = psd_pkg::COORD_BITS'(ex);
        q.end_y   = psd_pkg::COORD_BITS'(ey);
        q.query_x = psd_pkg::COORD_BITS'(qx);
        q.query_y = psd_pkg::COORD_BITS'(qy);
        return q;
    endfunction

    task automatic add_row(psd_pkg::query_t q, bit has_fixed,
                           logic [psd_pkg::DIST_W-1:0] dist_val, logic [1:0] part);
        directed_row_t row;
        row.q = q;
        row.has_fixed = has_fixed;
        row.fixed.distance = dist_val;
        row.fixed.nearest_part = part;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic build_directed();
        // All zeros: zero-length segment, point on it.
        add_row(make_query(0, 0, 0, 0, 0, 0), 1, '0, psd_pkg::PART_END);
        // Zero-length segment, point three-four-five away.
        add_row(make_query(7, 7, 7, 7, 10, 11), 1, psd_pkg::DIST_W'(5 * 256),
                psd_pkg::PART_END);
        // Beyond the second endpoint along the axis.
        add_row(make_query(0, 0, 10, 0, 13, 4), 1, psd_pkg::DIST_W'(5 * 256),
                psd_pkg::PART_END);
        // Behind the first endpoint.
        add_row(make_query(0, 0, 10, 0, -3, -4), 1, psd_pkg::DIST_W'(5 * 256),
                psd_pkg::PART_START);
        // Interior, straight above the middle.
        add_row(make_query(0, 0, 10, 0, 5, 6), 1, psd_pkg::DIST_W'(6 * 256),
                psd_pkg::PART_MID);
        // On the perpendicular through each endpoint: the equality picks it.
        add_row(make_query(0, 0, 10, 0, 10, 3), 1, psd_pkg::DIST_W'(3 * 256),
                psd_pkg::PART_END);
        add_row(make_query(0, 0, 10, 0, 0, 3), 1, psd_pkg::DIST_W'(3 * 256),
                psd_pkg::PART_START);
        // Point on the segment itself.
        add_row(make_query(-5, -5, 5, 5, 1, 1), 1, '0, psd_pkg::PART_MID);
        // Extreme coordinates, including the largest distance.
        add_row(make_query(-32768, -32768, -32768, -32768, 32767, 32767), 0, '0, '0);
        add_row(make_query(32767, 32767, 32767, 32767, -32768, -32768), 0, '0, '0);
        add_row(make_query(-32768, -32768, 32767, 32767, 32767, -32768), 0, '0, '0);
        add_row(make_query(-32768, 32767, 32767, -32768, -32768, -32768), 0, '0, '0);
        add_row(make_query(-32768, -32768, 32767, -32768, 0, 32767), 0, '0, '0);
        add_row(make_query(32767, -32768, -32768, 32767, 32767, 32767), 0, '0, '0);
        // Irrational distances, a diagonal interior case, a long thin one and a point on a zero-length segment.
        add_row(make_query(0, 0, 0, 0, 1, 1), 0, '0, '0);
        add_row(make_query(0, 0, 3, 7, 5, -2), 0, '0, '0);
        add_row(make_query(-30000, 1, 30000, 2, 17, -29999), 0, '0, '0);
        add_row(make_query(-1, -1, -1, -1, -1, -1), 1, '0, psd_pkg::PART_END);
    endtask

    // Offer one query; holds valid and the payload until the transfer.
    task automatic send_query(psd_pkg::query_t q, bit has_fixed,
                              psd_pkg::result_t fixed);
        psd_pkg::result_t expected;
        query <= q;
        query_valid <= 1'b1;
        @(posedge clk);
        while (!query_ready)
        begin
            @(posedge clk);
        end
        expected = has_fixed ? fixed : segment_distance(q);
        pending_results.insert(pending_results.size(), expected);
        @(negedge clk);
        // Idle cycles before the next query, each taken at the sender's rate.
        while ($urandom_range(99) < sender_idle_pct)
        begin
            query_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    function automatic int rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return ($urandom_range(1) != 0) ? 32767 : -32768;
        end
        else if (sel < 4)
        begin
            return $urandom_range(64) - 32;
        end
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic psd_pkg::query_t random_query();
        psd_pkg::query_t q;
        int bx, by;
        // Most queries cluster around one base point so that all three
        // nearest-part cases occur; the rest use raw random coordinates.
        if ($urandom_range(3) == 0)
        begin
            q = make_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord());
        end
        else
        begin
            bx = int'($urandom_range(65535)) - 32768;
            by = int'($urandom_range(65535)) - 32768;
            q = make_query(bx + rand_coord() / 4, by + rand_coord() / 4,
                           bx + rand_coord() / 4, by + rand_coord() / 4,
                           bx + rand_coord() / 4, by + rand_coord() / 4);
            if ($urandom_range(9) == 0)
            begin
                q.end_x = q.start_x;
                q.end_y = q.start_y;
            end
        end
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Stimulus: reset, directed table, then three idling phases of random
    // queries, with one long receiver hold-off and one full drain between.
    initial
    begin
        psd_pkg::result_t none;
        psd_pkg::query_t  q;
        none = '0;
        rst_n = 1'b0;
        query_valid = 1'b0;
        query = '0;
        stimulus_done = 1'b0;
        hold_results = 1'b0;
        sender_idle_pct = 37;
        receiver_idle_pct = 77;
        build_directed();
        repeat (12)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_query(directed_rows[i].q, directed_rows[i].has_fixed,
                       directed_rows[i].fixed);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 77;
                receiver_idle_pct = 37;
            end
            else if (n == RANDOM_ITEMS / 2)
            begin
                // The sender pauses until every result has come back.
                query_valid <= 1'b0;
                wait_drained();
            end
            else if (n == (2 * RANDOM_ITEMS) / 3)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
                // The receiver stalls long enough for the pipeline to fill.
                hold_results = 1'b1;
            end
            q = random_query();
            send_query(q, 1'b0, none);
        end
        query_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver readiness, with its own long hold-off counter.
    initial
    begin
        int hold_cycles;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                result_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 3 * PIPE_DEPTH)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
                hold_results = 1'b0;
            end
            result_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Result checking at each rising edge where a transfer occurs.
    always @(posedge clk)
    begin
        psd_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result: distance %0d part %0d",
                             result.distance, result.nearest_part);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.distance !== want.distance
                    || result.nearest_part !== want.nearest_part)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected distance %0d part %0d, got %0d part %0d",
                                 want.distance, want.nearest_part,
                                 result.distance, result.nearest_part);
                    end
                end
            end
        end
    end

    // Watchdog and end of run.
    initial
    begin
        bit timed_out;
        mismatch_count = 0;
        cycle_count = 0;
        timed_out = 1'b0;
        while (!(stimulus_done && pending_results.size() == 0) && !timed_out)
        begin
            @(posedge clk);
            cycle_count++;
            timed_out = (cycle_count > CYCLE_LIMIT);
        end
        if (!timed_out)
        begin
            // Let any stray result from the pipeline surface.
            repeat (2 * PIPE_DEPTH)
            begin
                @(posedge clk);
            end
        end
        if (!timed_out && mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("** point_segment_distance: PASSED **");
        end
        else
        begin
            $display("** point_segment_distance: FAILED **");
        end
        $finish;
    end

endmodule
